// ===== hw/rtl/dfbm_pkg.sv =====
// dfbm_pkg: types, codes and the control store of the dma fragment buffer manager
// no dependencies; imported by every module of the block

package dfbm_pkg;

  localparam int MAX_DMA_SLOTS   = 16;
  localparam int MAX_EXTRA_SLOTS = 64;
  localparam int MAX_RESULTS     = 5;
  localparam int PC_W            = 7;
  localparam int PADDR_W         = 4;

  typedef enum logic [2:0] {
    CMD_OPEN  = 3'd0,
    CMD_CLOSE = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_DONE  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    ACT_STATUS   = 4'd0,
    ACT_U2D      = 4'd1,
    ACT_U2E      = 4'd2,
    ACT_D2U      = 4'd3,
    ACT_E2U      = 4'd4,
    ACT_E2D      = 4'd5,
    ACT_D2E      = 4'd6,
    ACT_REPLY    = 4'd7,
    ACT_START    = 4'd8,
    ACT_PAUSE    = 4'd9,
    ACT_RESUME   = 4'd10,
    ACT_STOP     = 4'd11,
    ACT_REENABLE = 4'd12
  } act_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BUSY     = 2'd1,
    ST_BAD_SIZE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_DMA_FRAGMENTS = 2'd0,
    REG_EXTRA_BUFFERS = 2'd1,
    REG_FRAG_SIZE     = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_RUN   = 2'd1,
    SEQ_FLUSH = 2'd2
  } seq_e;

  typedef enum logic [4:0] {
    C_NEVER,
    C_ALWAYS,
    C_OPEN_OR_BUSY,
    C_SIZE_BAD,
    C_BUSY_NOT_WRITE,
    C_BUSY_NOT_READ,
    C_CLOSE_QUIET,
    C_BOTH_FULL,
    C_NOT_PENDING,
    C_DMA_FULL,
    C_NOT_OOD,
    C_BUSY,
    C_EMITTED,
    C_BOTH_EMPTY,
    C_EXTRA_EMPTY,
    C_NOT_BUSY,
    C_MODE_READ,
    C_MODE_NOT_WRITE,
    C_DMA_NONZERO,
    C_OPEN,
    C_DMA_NOT_FULL,
    C_EXTRA_NOT_FULL
  } cond_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_OPEN_INIT,
    OP_CLOSE_STOP,
    OP_CLEAR_OPEN,
    OP_SET_PENDING,
    OP_CLR_PENDING,
    OP_U2D,
    OP_U2E,
    OP_CLR_OOD,
    OP_SET_OOD,
    OP_START_W,
    OP_START_R,
    OP_E2U,
    OP_D2U,
    OP_DW_ADV,
    OP_E2D,
    OP_DR_FILL,
    OP_D2E,
    OP_CLR_BUSY
  } op_e;

  typedef struct packed {
    logic [4:0]  dma_fragments;
    logic [6:0]  extra_buffers;
    logic [15:0] frag_size;
  } cfg_t;

  typedef struct packed {
    cond_e            cond;
    logic [PC_W-1:0]  target;
    op_e              op;
    logic             emit;
    act_e             act;
    status_e          status;
    logic             len_zero;
    logic             done;
  } ucw_t;

  typedef struct packed {
    act_e        act;
    logic [3:0]  dma_slot;
    logic [5:0]  extra_slot;
    logic [15:0] reply_length;
    status_e     status;
  } item_t;

  localparam logic [PC_W-1:0] ENTRY_OPEN  = 7'd0;
  localparam logic [PC_W-1:0] ENTRY_CLOSE = 7'd3;
  localparam logic [PC_W-1:0] L_BUSY      = 7'd2;
  localparam logic [PC_W-1:0] L_BAD_SIZE  = 7'd6;
  localparam logic [PC_W-1:0] L_FIN       = 7'd7;
  localparam logic [PC_W-1:0] ENTRY_WRITE = 7'd8;
  localparam logic [PC_W-1:0] ENTRY_READ  = 7'd24;
  localparam logic [PC_W-1:0] ENTRY_DONE  = 7'd36;
  localparam logic [PC_W-1:0] L_REEN      = 7'd56;
  localparam logic [PC_W-1:0] L_DONE_READ = 7'd57;

  // branch only
  function automatic ucw_t br(input cond_e c, input logic [PC_W-1:0] t);
    ucw_t w;
    w        = '0;
    w.cond   = c;
    w.target = t;
    w.op     = OP_NONE;
    w.act    = ACT_STATUS;
    w.status = ST_OK;
    return w;
  endfunction

  // state update with optional beat, then fall through or finish
  function automatic ucw_t ex(input op_e o, input logic e, input act_e a, input logic d);
    ucw_t w;
    w        = '0;
    w.cond   = C_NEVER;
    w.op     = o;
    w.emit   = e;
    w.act    = a;
    w.status = ST_OK;
    w.done   = d;
    return w;
  endfunction

  // state update with beat, then jump
  function automatic ucw_t exj(input op_e o, input act_e a, input logic [PC_W-1:0] t);
    ucw_t w;
    w        = ex(o, 1'b1, a, 1'b0);
    w.cond   = C_ALWAYS;
    w.target = t;
    return w;
  endfunction

  // status-only beat that ends the event
  function automatic ucw_t sto(input status_e s);
    ucw_t w;
    w        = ex(OP_NONE, 1'b1, ACT_STATUS, 1'b1);
    w.status = s;
    return w;
  endfunction

  function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
    ucw_t w;
    case (pc)
      // open
      7'd0:  w = br(C_OPEN_OR_BUSY, L_BUSY);
      7'd1:  w = ex(OP_OPEN_INIT, 1'b1, ACT_STATUS, 1'b1);
      7'd2:  w = sto(ST_BUSY);
      // close
      7'd3:  w = br(C_CLOSE_QUIET, 7'd5);
      7'd4:  w = ex(OP_CLOSE_STOP, 1'b1, ACT_STOP, 1'b1);
      7'd5:  w = ex(OP_CLEAR_OPEN, 1'b1, ACT_STATUS, 1'b1);
      7'd6:  w = sto(ST_BAD_SIZE);
      7'd7:  w = ex(OP_NONE, 1'b0, ACT_STATUS, 1'b1);
      // user write
      7'd8:  w = br(C_SIZE_BAD, L_BAD_SIZE);
      7'd9:  w = br(C_BUSY_NOT_WRITE, L_BUSY);
      7'd10: w = ex(OP_SET_PENDING, 1'b0, ACT_STATUS, 1'b0);
      7'd11: w = br(C_BOTH_FULL, 7'd20);
      7'd12: w = br(C_NOT_PENDING, 7'd20);
      7'd13: w = br(C_DMA_FULL, 7'd15);
      7'd14: w = exj(OP_U2D, ACT_U2D, 7'd16);
      7'd15: w = ex(OP_U2E, 1'b1, ACT_U2E, 1'b0);
      7'd16: w = br(C_NOT_OOD, 7'd19);
      7'd17: w = ex(OP_CLR_OOD, 1'b1, ACT_REENABLE, 1'b0);
      7'd18: w = ex(OP_NONE, 1'b1, ACT_RESUME, 1'b0);
      7'd19: w = ex(OP_CLR_PENDING, 1'b1, ACT_REPLY, 1'b0);
      7'd20: w = br(C_BUSY, 7'd22);
      7'd21: w = ex(OP_START_W, 1'b1, ACT_START, 1'b0);
      7'd22: w = br(C_EMITTED, L_FIN);
      7'd23: w = sto(ST_OK);
      // user read
      7'd24: w = br(C_SIZE_BAD, L_BAD_SIZE);
      7'd25: w = br(C_BUSY_NOT_READ, L_BUSY);
      7'd26: w = ex(OP_SET_PENDING, 1'b0, ACT_STATUS, 1'b0);
      7'd27: w = br(C_BUSY, 7'd29);
      7'd28: w = ex(OP_START_R, 1'b1, ACT_START, 1'b1);
      7'd29: w = br(C_BOTH_EMPTY, 7'd34);
      7'd30: w = br(C_EXTRA_EMPTY, 7'd32);
      7'd31: w = exj(OP_E2U, ACT_E2U, 7'd33);
      7'd32: w = ex(OP_D2U, 1'b1, ACT_D2U, 1'b0);
      7'd33: w = ex(OP_CLR_PENDING, 1'b1, ACT_REPLY, 1'b0);
      7'd34: w = br(C_EMITTED, L_FIN);
      7'd35: w = sto(ST_OK);
      // fragment done, playback side
      7'd36: w = br(C_NOT_BUSY, L_REEN);
      7'd37: w = br(C_MODE_READ, L_DONE_READ);
      7'd38: w = br(C_MODE_NOT_WRITE, L_REEN);
      7'd39: w = ex(OP_DW_ADV, 1'b0, ACT_STATUS, 1'b0);
      7'd40: w = br(C_EXTRA_EMPTY, 7'd42);
      7'd41: w = ex(OP_E2D, 1'b1, ACT_E2D, 1'b0);
      7'd42: w = br(C_BOTH_FULL, 7'd51);
      7'd43: w = br(C_NOT_PENDING, 7'd51);
      7'd44: w = br(C_DMA_FULL, 7'd46);
      7'd45: w = exj(OP_U2D, ACT_U2D, 7'd47);
      7'd46: w = ex(OP_U2E, 1'b1, ACT_U2E, 1'b0);
      7'd47: w = br(C_NOT_OOD, 7'd50);
      7'd48: w = ex(OP_CLR_OOD, 1'b1, ACT_REENABLE, 1'b0);
      7'd49: w = ex(OP_NONE, 1'b1, ACT_RESUME, 1'b0);
      7'd50: w = ex(OP_CLR_PENDING, 1'b1, ACT_REPLY, 1'b0);
      7'd51: w = br(C_DMA_NONZERO, L_REEN);
      7'd52: w = ex(OP_SET_OOD, 1'b0, ACT_STATUS, 1'b0);
      7'd53: w = br(C_OPEN, 7'd55);
      7'd54: w = exj(OP_CLOSE_STOP, ACT_STOP, L_REEN);
      7'd55: w = ex(OP_NONE, 1'b1, ACT_PAUSE, 1'b0);
      7'd56: w = ex(OP_NONE, 1'b1, ACT_REENABLE, 1'b1);
      // fragment done, capture side
      7'd57: w = ex(OP_DR_FILL, 1'b0, ACT_STATUS, 1'b0);
      7'd58: w = br(C_NOT_PENDING, 7'd64);
      7'd59: w = br(C_BOTH_EMPTY, 7'd64);
      7'd60: w = br(C_EXTRA_EMPTY, 7'd62);
      7'd61: w = exj(OP_E2U, ACT_E2U, 7'd63);
      7'd62: w = ex(OP_D2U, 1'b1, ACT_D2U, 1'b0);
      7'd63: w = ex(OP_CLR_PENDING, 1'b1, ACT_REPLY, 1'b0);
      7'd64: w = br(C_DMA_NOT_FULL, L_REEN);
      7'd65: w = br(C_EXTRA_NOT_FULL, 7'd69);
      7'd66: w = ex(OP_CLR_BUSY, 1'b1, ACT_STOP, 1'b0);
      7'd67: w = br(C_NOT_PENDING, L_REEN);
      7'd68: begin
        w          = exj(OP_CLR_PENDING, ACT_REPLY, L_REEN);
        w.len_zero = 1'b1;
      end
      7'd69: w = exj(OP_D2E, ACT_D2E, L_REEN);
      default: w = ex(OP_NONE, 1'b0, ACT_STATUS, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/dfbm_cfg.sv =====
// dfbm_cfg: configuration registers behind the apb-style port
// depends on dfbm_pkg

module dfbm_cfg import dfbm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [31:0]        pwdata_i,
  output logic [31:0]        prdata_o,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign wr_en = psel_i & penable_i & pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr_i[3:2])
        REG_DMA_FRAGMENTS: cfg_d.dma_fragments = pwdata_i[4:0];
        REG_EXTRA_BUFFERS: cfg_d.extra_buffers = pwdata_i[6:0];
        REG_FRAG_SIZE:     cfg_d.frag_size     = pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[3:2])
      REG_DMA_FRAGMENTS: prdata_o = {27'd0, cfg_q.dma_fragments};
      REG_EXTRA_BUFFERS: prdata_o = {25'd0, cfg_q.extra_buffers};
      REG_FRAG_SIZE:     prdata_o = {16'd0, cfg_q.frag_size};
      default:           prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dma_fragments <= 5'd2;
      cfg_q.extra_buffers <= 7'd8;
      cfg_q.frag_size     <= 16'd4096;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/dfbm_datapath.sv =====
// dfbm_datapath: channel state, ring indices and counts, branch conditions, beat builder
// depends on dfbm_pkg; driven one control word at a time by the sequencer

module dfbm_datapath import dfbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        start_i,
  input  logic [1:0]  mode_i,
  input  logic [15:0] size_i,
  input  logic        exec_i,
  input  ucw_t        ucw_i,
  input  logic        emitted_i,
  output logic        cond_o,
  output item_t       item_o
);

  localparam logic [4:0] DMA_MAX   = 5'(MAX_DMA_SLOTS);
  localparam logic [6:0] EXTRA_MAX = 7'(MAX_EXTRA_SLOTS);

  logic        open_q, open_d;
  logic        busy_q, busy_d;
  mode_e       tmode_q, tmode_d;
  logic [3:0]  dread_q, dread_d, dfill_q, dfill_d;
  logic [4:0]  dcount_q, dcount_d;
  logic [5:0]  eread_q, eread_d, efill_q, efill_d;
  logic [6:0]  ecount_q, ecount_d;
  logic        pending_q, pending_d;
  logic        ood_q, ood_d;

  logic [1:0]  in_mode_q;
  logic [15:0] in_size_q;

  logic [4:0]  nd;
  logic [6:0]  ne;
  logic        dfull, efull;

  function automatic logic [3:0] adv_d(input logic [3:0] i, input logic [4:0] n);
    logic [4:0] nx;
    nx = {1'b0, i} + 5'd1;
    return (nx >= n) ? 4'd0 : nx[3:0];
  endfunction

  function automatic logic [5:0] adv_e(input logic [5:0] i, input logic [6:0] n);
    logic [6:0] nx;
    nx = {1'b0, i} + 7'd1;
    return (nx >= n) ? 6'd0 : nx[5:0];
  endfunction

  assign nd = (cfg_i.dma_fragments == 5'd0) ? 5'd1 :
              (cfg_i.dma_fragments > DMA_MAX) ? DMA_MAX : cfg_i.dma_fragments;
  assign ne = (cfg_i.extra_buffers == 7'd0) ? 7'd1 :
              (cfg_i.extra_buffers > EXTRA_MAX) ? EXTRA_MAX : cfg_i.extra_buffers;
  assign dfull = dcount_q >= nd;
  assign efull = ecount_q >= ne;

  always_comb begin
    case (ucw_i.cond)
      C_NEVER:          cond_o = 1'b0;
      C_ALWAYS:         cond_o = 1'b1;
      C_OPEN_OR_BUSY:   cond_o = open_q | busy_q;
      C_SIZE_BAD:       cond_o = in_size_q != cfg_i.frag_size;
      C_BUSY_NOT_WRITE: cond_o = busy_q && (tmode_q != MODE_WRITE);
      C_BUSY_NOT_READ:  cond_o = busy_q && (tmode_q != MODE_READ);
      C_CLOSE_QUIET:    cond_o = ((tmode_q == MODE_WRITE) && !ood_q) || (tmode_q == MODE_NONE);
      C_BOTH_FULL:      cond_o = dfull & efull;
      C_NOT_PENDING:    cond_o = !pending_q;
      C_DMA_FULL:       cond_o = dfull;
      C_NOT_OOD:        cond_o = !ood_q;
      C_BUSY:           cond_o = busy_q;
      C_EMITTED:        cond_o = emitted_i;
      C_BOTH_EMPTY:     cond_o = (ecount_q == 7'd0) && (dcount_q == 5'd0);
      C_EXTRA_EMPTY:    cond_o = ecount_q == 7'd0;
      C_NOT_BUSY:       cond_o = !busy_q;
      C_MODE_READ:      cond_o = tmode_q == MODE_READ;
      C_MODE_NOT_WRITE: cond_o = tmode_q != MODE_WRITE;
      C_DMA_NONZERO:    cond_o = dcount_q != 5'd0;
      C_OPEN:           cond_o = open_q;
      C_DMA_NOT_FULL:   cond_o = !dfull;
      C_EXTRA_NOT_FULL: cond_o = !efull;
      default:          cond_o = 1'b0;
    endcase
  end

  always_comb begin
    open_d    = open_q;
    busy_d    = busy_q;
    tmode_d   = tmode_q;
    dread_d   = dread_q;
    dfill_d   = dfill_q;
    dcount_d  = dcount_q;
    eread_d   = eread_q;
    efill_d   = efill_q;
    ecount_d  = ecount_q;
    pending_d = pending_q;
    ood_d     = ood_q;
    if (exec_i) begin
      case (ucw_i.op)
        OP_OPEN_INIT: begin
          open_d    = 1'b1;
          dread_d   = '0;
          dfill_d   = '0;
          dcount_d  = '0;
          eread_d   = '0;
          efill_d   = '0;
          ecount_d  = '0;
          pending_d = 1'b0;
          ood_d     = 1'b1;
          tmode_d   = (in_mode_q == MODE_WRITE) ? MODE_WRITE :
                      (in_mode_q == MODE_READ)  ? MODE_READ  : MODE_NONE;
        end
        OP_CLOSE_STOP: begin
          open_d = 1'b0;
          busy_d = 1'b0;
        end
        OP_CLEAR_OPEN:  open_d    = 1'b0;
        OP_SET_PENDING: pending_d = 1'b1;
        OP_CLR_PENDING: pending_d = 1'b0;
        OP_U2D: begin
          dcount_d = dfull ? dcount_q : dcount_q + 5'd1;
          dfill_d  = adv_d(dfill_q, nd);
        end
        OP_U2E: begin
          ecount_d = efull ? ecount_q : ecount_q + 7'd1;
          efill_d  = adv_e(efill_q, ne);
        end
        OP_CLR_OOD: ood_d = 1'b0;
        OP_SET_OOD: ood_d = 1'b1;
        OP_START_W: begin
          busy_d  = 1'b1;
          dread_d = '0;
          tmode_d = MODE_WRITE;
        end
        OP_START_R: begin
          busy_d  = 1'b1;
          dread_d = '0;
          tmode_d = MODE_READ;
        end
        OP_E2U: begin
          eread_d  = adv_e(eread_q, ne);
          ecount_d = (ecount_q == 7'd0) ? ecount_q : ecount_q - 7'd1;
        end
        OP_D2U, OP_DW_ADV: begin
          dread_d  = adv_d(dread_q, nd);
          dcount_d = (dcount_q == 5'd0) ? dcount_q : dcount_q - 5'd1;
        end
        OP_E2D: begin
          eread_d  = adv_e(eread_q, ne);
          dfill_d  = adv_d(dfill_q, nd);
          ecount_d = (ecount_q == 7'd0) ? ecount_q : ecount_q - 7'd1;
          dcount_d = dfull ? dcount_q : dcount_q + 5'd1;
        end
        OP_DR_FILL: begin
          dcount_d = dfull ? dcount_q : dcount_q + 5'd1;
          dfill_d  = adv_d(dfill_q, nd);
        end
        OP_D2E: begin
          dcount_d = (dcount_q == 5'd0) ? dcount_q : dcount_q - 5'd1;
          dread_d  = adv_d(dread_q, nd);
          ecount_d = efull ? ecount_q : ecount_q + 7'd1;
          efill_d  = adv_e(efill_q, ne);
        end
        OP_CLR_BUSY: busy_d = 1'b0;
        default: ;
      endcase
    end
  end

  // beat fields, slots taken before the step's own update
  always_comb begin
    item_o.act          = ucw_i.act;
    item_o.status       = ucw_i.status;
    item_o.reply_length = (ucw_i.act == ACT_REPLY && !ucw_i.len_zero) ? cfg_i.frag_size : 16'd0;
    case (ucw_i.act)
      ACT_U2D, ACT_E2D: item_o.dma_slot = dfill_q;
      ACT_D2U, ACT_D2E: item_o.dma_slot = dread_q;
      default:          item_o.dma_slot = 4'd0;
    endcase
    case (ucw_i.act)
      ACT_U2E, ACT_D2E: item_o.extra_slot = efill_q;
      ACT_E2U, ACT_E2D: item_o.extra_slot = eread_q;
      default:          item_o.extra_slot = 6'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= 1'b0;
      busy_q    <= 1'b0;
      tmode_q   <= MODE_NONE;
      dread_q   <= '0;
      dfill_q   <= '0;
      dcount_q  <= '0;
      eread_q   <= '0;
      efill_q   <= '0;
      ecount_q  <= '0;
      pending_q <= 1'b0;
      ood_q     <= 1'b0;
    end else begin
      open_q    <= open_d;
      busy_q    <= busy_d;
      tmode_q   <= tmode_d;
      dread_q   <= dread_d;
      dfill_q   <= dfill_d;
      dcount_q  <= dcount_d;
      eread_q   <= eread_d;
      efill_q   <= efill_d;
      ecount_q  <= ecount_d;
      pending_q <= pending_d;
      ood_q     <= ood_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_mode_q <= mode_i;
      in_size_q <= size_i;
    end
  end

endmodule

// ===== hw/rtl/dma_fragment_buffer_manager_unit.sv =====
// dma_fragment_buffer_manager_unit: top level, microcoded sequencer and output stage
// depends on dfbm_pkg, dfbm_cfg and dfbm_datapath
//
// one event beat in on the s_axis side: tuser carries the command, tdata the open
// mode and request size. the block answers with one to five action beats on the
// m_axis side; tuser carries the action code and tlast marks the final beat of
// the event. events with an unknown command are taken and produce no beat.
// dma_fragments, extra_buffers and frag_size sit at byte addresses 0, 4 and 8 of the
// apb-style port; write them only while no event is open, the block does not check.
// an event runs as a short program from the control store, one control word per clock
// while the sequencer is not stalled, and a beat on the word that builds it; each beat
// waits in a hold register until the next beat or the end of the event moves it to
// the output register.
// one event is in flight at a time; s_axis_tready rises again once the final
// beat has been handed to the output register, which holds it while m_axis_tready
// is low and stalls the sequencer at its next beat.
// reset clears the channel state and loads the register defaults (2, 8, 4096);
// there is no clearing pass and the block takes an event on the first cycle.

module dma_fragment_buffer_manager_unit import dfbm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,  // open_mode[1:0], request_size[17:2]
  input  logic [2:0]         s_axis_tuser,  // cmd[2:0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,  // dma_slot[3:0], extra_slot[9:4],
                                            // reply_length[25:10], status[27:26]
  output logic [3:0]         m_axis_tuser,  // action[3:0]
  output logic               m_axis_tlast,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t            cfg;
  ucw_t            ucw;
  item_t           item;
  logic            cond;

  seq_e            state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            hold_valid_q, hold_valid_d;
  item_t           hold_q;
  logic            out_valid_q, out_valid_d;
  item_t           out_q;
  logic            out_last_q;

  logic            accept, exec, can_emit, out_free;
  logic            hold_load, out_load, load_last;

  assign pready = 1'b1;

  dfbm_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  dfbm_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .start_i   (accept),
    .mode_i    (s_axis_tdata[1:0]),
    .size_i    (s_axis_tdata[17:2]),
    .exec_i    (exec),
    .ucw_i     (ucw),
    .emitted_i (cnt_q != 3'd0),
    .cond_o    (cond),
    .item_o    (item)
  );

  assign ucw           = ucode_rom(pc_q);
  assign s_axis_tready = state_q == SEQ_IDLE;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign can_emit      = ucw.emit && (cnt_q < 3'(MAX_RESULTS));

  always_comb begin
    state_d      = state_q;
    pc_d         = pc_q;
    cnt_d        = cnt_q;
    hold_valid_d = hold_valid_q;
    hold_load    = 1'b0;
    out_load     = 1'b0;
    load_last    = 1'b0;
    exec         = 1'b0;
    unique case (state_q)
      SEQ_IDLE: begin
        if (s_axis_tvalid) begin
          cnt_d = 3'd0;
          unique case (s_axis_tuser)
            CMD_OPEN:  begin state_d = SEQ_RUN; pc_d = ENTRY_OPEN;  end
            CMD_CLOSE: begin state_d = SEQ_RUN; pc_d = ENTRY_CLOSE; end
            CMD_WRITE: begin state_d = SEQ_RUN; pc_d = ENTRY_WRITE; end
            CMD_READ:  begin state_d = SEQ_RUN; pc_d = ENTRY_READ;  end
            CMD_DONE:  begin state_d = SEQ_RUN; pc_d = ENTRY_DONE;  end
            default: ;
          endcase
        end
      end
      SEQ_RUN: begin
        if (!(can_emit && hold_valid_q && !out_free)) begin
          exec = 1'b1;
          if (can_emit) begin
            hold_load    = 1'b1;
            hold_valid_d = 1'b1;
            cnt_d        = cnt_q + 3'd1;
            out_load     = hold_valid_q;
          end
          if (ucw.done) begin
            state_d = SEQ_FLUSH;
          end else if (cond) begin
            pc_d = ucw.target;
          end else begin
            pc_d = pc_q + 7'd1;
          end
        end
      end
      SEQ_FLUSH: begin
        if (!hold_valid_q) begin
          state_d = SEQ_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          load_last    = 1'b1;
          hold_valid_d = 1'b0;
          state_d      = SEQ_IDLE;
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
    out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SEQ_IDLE;
      pc_q         <= '0;
      cnt_q        <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pc_q         <= pc_d;
      cnt_q        <= cnt_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_load) begin
      hold_q <= item;
    end
    if (out_load) begin
      out_q      <= hold_q;
      out_last_q <= load_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_q.act;
  assign m_axis_tdata  = {4'd0, out_q.status, out_q.reply_length,
                          out_q.extra_slot, out_q.dma_slot};

endmodule
